FILE: hw/rtl/zpc_pkg.sv
`default_nettype none
package zpc_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int KERNEL_SIZE = 3;
  localparam int COEF_BITS   = 8;

  localparam int PIX_W      = 8;
  localparam int DIM_W      = 11;
  localparam int KROW_W     = 24;
  localparam int DIVR_W     = 9;
  localparam int IDX_W      = 3;
  localparam int CFG_DATA_W = 24;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT) + 1;
  localparam int OROW_W = $clog2(MAX_HEIGHT);

  localparam int PROD_W = COEF_BITS + PIX_W + 1;
  localparam int SUM_W  = PROD_W + 4;
  localparam int MAG_W  = SUM_W - 1;
  localparam int CNT_W  = $clog2(MAG_W + 1);

  localparam int LINE_W      = 2 * PIX_W;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  localparam logic [IDX_W-1:0] REG_WIDTH   = 3'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_KTOP    = 3'd2;
  localparam logic [IDX_W-1:0] REG_KMID    = 3'd3;
  localparam logic [IDX_W-1:0] REG_KBOT    = 3'd4;
  localparam logic [IDX_W-1:0] REG_DIVISOR = 3'd5;

  // One queued item: the stored sample and the border situation of the
  // output it produces (if any).
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [COL_W-1:0] col;
    logic             emit;
    logic             top;
    logic             bottom;
    logic             left;
    logic             right;
    logic             last;
  } item_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SHIFT = 6'b000010,
    S_MUL   = 6'b000100,
    S_SUM   = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } back_state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/zpc_if.sv
`default_nettype none
interface zpc_in_if;
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic [zpc_pkg::PIX_W-1:0] pixel;
  modport source (output valid, output mode, output pixel, input ready);
  modport sink   (input valid, input mode, input pixel, output ready);
endinterface

interface zpc_out_if;
  logic                    valid;
  logic                    ready;
  logic [zpc_pkg::PIX_W-1:0] pixel_out;
  logic                    frame_last;
  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

interface zpc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [zpc_pkg::IDX_W-1:0]      index;
  logic [zpc_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/zpc_ram.sv
`default_nettype none
module zpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: hw/rtl/zpc_fifo.sv
`default_nettype none
module zpc_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire zpc_pkg::item_t  push_item,
  output      logic            full,
  input  wire logic            pop,
  output      logic            empty,
  output      zpc_pkg::item_t  head
);

  localparam int PTR_W = (zpc_pkg::QUEUE_DEPTH > 1) ? $clog2(zpc_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(zpc_pkg::QUEUE_DEPTH + 1);

  zpc_pkg::item_t   slot_r [zpc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(zpc_pkg::QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  assign full  = (count_r == CNT_W'(zpc_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/zpc_front.sv
`default_nettype none
module zpc_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  zpc_in_if.sink                         in_ch,
  input  wire logic                      restart,
  input  wire logic [zpc_pkg::DIM_W-1:0] eff_w,
  input  wire logic [zpc_pkg::DIM_W-1:0] eff_h,
  input  wire logic                      full,
  output      logic                      push,
  output      zpc_pkg::item_t            push_item
);

  logic [zpc_pkg::COL_W-1:0]  ic_r, oc_r;
  logic [zpc_pkg::ROW_W-1:0]  ir_r;
  logic [zpc_pkg::OROW_W-1:0] or_r;
  logic                       in_row_end, out_row_end;

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;

  assign in_row_end  = ({1'b0, ic_r} + zpc_pkg::DIM_W'(1)) >= eff_w;
  assign out_row_end = ({1'b0, oc_r} + zpc_pkg::DIM_W'(1)) >= eff_w;

  always_comb begin
    push_item.pix    = (!in_ch.mode && (ir_r < eff_h)) ? in_ch.pixel : '0;
    push_item.col    = ic_r;
    push_item.emit   = (ir_r >= zpc_pkg::ROW_W'(2)) ||
                       ((ir_r == zpc_pkg::ROW_W'(1)) && (ic_r != '0));
    push_item.top    = (or_r == '0);
    push_item.bottom = ({1'b0, or_r} + zpc_pkg::DIM_W'(1)) >= eff_h;
    push_item.left   = (oc_r == '0);
    push_item.right  = out_row_end;
    push_item.last   = push_item.emit && push_item.bottom && out_row_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      ic_r <= '0;
      ir_r <= '0;
      oc_r <= '0;
      or_r <= '0;
    end else if (push) begin
      if (push_item.last) begin
        ic_r <= '0;
        ir_r <= '0;
        oc_r <= '0;
        or_r <= '0;
      end else begin
        if (in_row_end) begin
          ic_r <= '0;
          ir_r <= ir_r + zpc_pkg::ROW_W'(1);
        end else begin
          ic_r <= ic_r + zpc_pkg::COL_W'(1);
        end
        if (push_item.emit) begin
          if (out_row_end) begin
            oc_r <= '0;
            or_r <= or_r + zpc_pkg::OROW_W'(1);
          end else begin
            oc_r <= oc_r + zpc_pkg::COL_W'(1);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/zpc_back.sv
`default_nettype none
module zpc_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        empty,
  input  wire zpc_pkg::item_t              head,
  output      logic                        pop,
  input  wire logic [zpc_pkg::KROW_W-1:0]  krow [zpc_pkg::KERNEL_SIZE],
  input  wire logic [zpc_pkg::DIVR_W-1:0]  divisor,
  zpc_out_if.source                        out_ch
);

  localparam int K = zpc_pkg::KERNEL_SIZE;
  localparam int P = zpc_pkg::PIX_W;

  zpc_pkg::back_state_t              state_r;
  zpc_pkg::item_t                    cur_r;
  logic [P-1:0]                      win_r  [K][K];
  logic signed [zpc_pkg::PROD_W-1:0] prod_r [K][K];
  logic signed [zpc_pkg::PROD_W-1:0] prod_nxt [K][K];
  logic signed [zpc_pkg::SUM_W-1:0]  sum_nxt;
  logic [zpc_pkg::MAG_W-1:0]         sum_mag, quo_r;
  logic [zpc_pkg::DIVR_W-1:0]        rem_r, dmag_r, rem_nxt, div_mag;
  logic [zpc_pkg::DIVR_W:0]          shifted;
  logic                              ge;
  logic                              neg_r;
  logic [zpc_pkg::CNT_W-1:0]         cnt_r;
  logic [P-1:0]                      res_r, res_sum, res_quo;
  logic                              last_r;
  logic [zpc_pkg::LINE_W-1:0]        line_rd;

  // Line store word: upper byte two rows up, lower byte one row up.
  zpc_ram #(.WIDTH(zpc_pkg::LINE_W), .DEPTH(zpc_pkg::MAX_WIDTH)) u_line (
    .clk   (clk),
    .we    (state_r == zpc_pkg::S_SHIFT),
    .waddr (cur_r.col),
    .wdata ({line_rd[P-1:0], cur_r.pix}),
    .re    (pop),
    .raddr (head.col),
    .rdata (line_rd)
  );

  assign pop = (state_r == zpc_pkg::S_IDLE) && !empty;

  always_comb begin
    for (int x = 0; x < K; x++) begin
      for (int y = 0; y < K; y++) begin
        logic [P-1:0]                  tap;
        logic signed [zpc_pkg::COEF_BITS-1:0] coef;
        tap  = ((x == 0 && cur_r.top) || (x == K - 1 && cur_r.bottom) ||
                (y == 0 && cur_r.left) || (y == K - 1 && cur_r.right)) ? '0 : win_r[x][y];
        coef = krow[x][y*zpc_pkg::COEF_BITS +: zpc_pkg::COEF_BITS];
        prod_nxt[x][y] = zpc_pkg::PROD_W'(coef * $signed({1'b0, tap}));
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int x = 0; x < K; x++) begin
      for (int y = 0; y < K; y++) begin
        sum_nxt = sum_nxt + zpc_pkg::SUM_W'(prod_r[x][y]);
      end
    end
  end

  assign sum_mag = sum_nxt[zpc_pkg::SUM_W-1] ? zpc_pkg::MAG_W'(-sum_nxt)
                                             : sum_nxt[zpc_pkg::MAG_W-1:0];
  assign div_mag = divisor[zpc_pkg::DIVR_W-1] ? (~divisor + zpc_pkg::DIVR_W'(1)) : divisor;

  // Clamp to the pixel range.
  assign res_sum = sum_nxt[zpc_pkg::SUM_W-1] ? '0 :
                   (sum_nxt > zpc_pkg::SUM_W'(zpc_pkg::PIX_MAX)) ? zpc_pkg::PIX_MAX
                                                                 : sum_nxt[P-1:0];
  assign res_quo = neg_r ? '0 :
                   (quo_r > zpc_pkg::MAG_W'(zpc_pkg::PIX_MAX)) ? zpc_pkg::PIX_MAX
                                                               : quo_r[P-1:0];

  // One restoring step per cycle on the magnitudes.
  assign shifted = {rem_r, quo_r[zpc_pkg::MAG_W-1]};
  assign ge      = shifted >= {1'b0, dmag_r};
  assign rem_nxt = ge ? zpc_pkg::DIVR_W'(shifted - {1'b0, dmag_r})
                      : shifted[zpc_pkg::DIVR_W-1:0];

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
    if (state_r == zpc_pkg::S_SHIFT) begin
      for (int x = 0; x < K; x++) begin
        for (int y = 0; y < K - 1; y++) begin
          win_r[x][y] <= win_r[x][y+1];
        end
      end
      win_r[0][K-1] <= line_rd[zpc_pkg::LINE_W-1:P];
      win_r[1][K-1] <= line_rd[P-1:0];
      win_r[2][K-1] <= cur_r.pix;
    end
    if (state_r == zpc_pkg::S_MUL) begin
      prod_r <= prod_nxt;
    end
    if (state_r == zpc_pkg::S_SUM) begin
      quo_r  <= sum_mag;
      rem_r  <= '0;
      dmag_r <= div_mag;
      neg_r  <= sum_nxt[zpc_pkg::SUM_W-1] ^ divisor[zpc_pkg::DIVR_W-1];
      cnt_r  <= zpc_pkg::CNT_W'(zpc_pkg::MAG_W);
      res_r  <= res_sum;
      last_r <= cur_r.last;
    end
    if (state_r == zpc_pkg::S_DIV) begin
      if (cnt_r == '0) begin
        res_r <= res_quo;
      end else begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[zpc_pkg::MAG_W-2:0], ge};
        cnt_r <= cnt_r - zpc_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= zpc_pkg::S_IDLE;
    end else begin
      case (state_r)
        zpc_pkg::S_IDLE: begin
          if (pop) begin
            state_r <= zpc_pkg::S_SHIFT;
          end
        end
        zpc_pkg::S_SHIFT: begin
          state_r <= cur_r.emit ? zpc_pkg::S_MUL : zpc_pkg::S_IDLE;
        end
        zpc_pkg::S_MUL: begin
          state_r <= zpc_pkg::S_SUM;
        end
        zpc_pkg::S_SUM: begin
          state_r <= (divisor == '0) ? zpc_pkg::S_OUT : zpc_pkg::S_DIV;
        end
        zpc_pkg::S_DIV: begin
          if (cnt_r == '0) begin
            state_r <= zpc_pkg::S_OUT;
          end
        end
        zpc_pkg::S_OUT: begin
          if (out_ch.ready) begin
            state_r <= zpc_pkg::S_IDLE;
          end
        end
        default: begin
          state_r <= zpc_pkg::S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid      = (state_r == zpc_pkg::S_OUT);
  assign out_ch.pixel_out  = res_r;
  assign out_ch.frame_last = last_r;

endmodule
`default_nettype wire

FILE: hw/rtl/zero_padded_convolution_3x3.sv
`default_nettype none
// 3x3 convolution with zero padding over an 8-bit grayscale raster stream.
// Feed pixels in raster order on in_ch (mode 0); after each frame send
// image_width+1 flush transfers (mode 1) to drain the last outputs. The
// output for frame position p leaves on out_ch after the input transfer at
// stream position p+image_width+1, and frame_last marks the final pixel of
// the frame. Each sum of signed kernel coefficients times neighbors is
// divided by a nonzero divisor (truncating toward zero) and clamped to
// 0..255. The front end counts positions and classifies each transfer into
// a two-entry queue; the back end works one item at a time over one line
// store port. A transfer that yields no output only shifts the window and
// line store; one that yields one also multiplies, sums, runs a 20-step
// serial divider if the divisor is nonzero, and may stall on out_ch. Writing
// image_width or image_height restarts the frame; kernel and divisor writes
// apply to the next output. Write configuration only while the block is idle.
module zero_padded_convolution_3x3 (
  input  wire logic   clk,
  input  wire logic   rst_n,
  zpc_cfg_if.sink     cfg_ch,
  zpc_in_if.sink      in_ch,
  zpc_out_if.source   out_ch
);

  // Configuration registers.
  logic [zpc_pkg::DIM_W-1:0]  width_r, height_r;
  logic [zpc_pkg::KROW_W-1:0] krow_r [zpc_pkg::KERNEL_SIZE];
  logic [zpc_pkg::DIVR_W-1:0] divisor_r;
  logic [zpc_pkg::DIM_W-1:0]  eff_w, eff_h;
  logic                       restart;

  // Front-to-back queue.
  logic           push, pop, full, empty;
  zpc_pkg::item_t push_item, head;

  assign cfg_ch.ready = 1'b1;

  // Restart the frame on any geometry write.
  assign restart = cfg_ch.valid &&
                   ((cfg_ch.index == zpc_pkg::REG_WIDTH) ||
                    (cfg_ch.index == zpc_pkg::REG_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= zpc_pkg::DIM_W'(640);
      height_r  <= zpc_pkg::DIM_W'(480);
      krow_r[0] <= '0;
      krow_r[1] <= zpc_pkg::KROW_W'(256);
      krow_r[2] <= '0;
      divisor_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        zpc_pkg::REG_WIDTH:   width_r   <= cfg_ch.data[zpc_pkg::DIM_W-1:0];
        zpc_pkg::REG_HEIGHT:  height_r  <= cfg_ch.data[zpc_pkg::DIM_W-1:0];
        zpc_pkg::REG_KTOP:    krow_r[0] <= cfg_ch.data[zpc_pkg::KROW_W-1:0];
        zpc_pkg::REG_KMID:    krow_r[1] <= cfg_ch.data[zpc_pkg::KROW_W-1:0];
        zpc_pkg::REG_KBOT:    krow_r[2] <= cfg_ch.data[zpc_pkg::KROW_W-1:0];
        zpc_pkg::REG_DIVISOR: divisor_r <= cfg_ch.data[zpc_pkg::DIVR_W-1:0];
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  // Treat zero as one; saturate width at the line store size, height at MAX_HEIGHT.
  assign eff_w = (width_r == '0) ? zpc_pkg::DIM_W'(1) :
                 (width_r > zpc_pkg::DIM_W'(zpc_pkg::MAX_WIDTH)) ?
                 zpc_pkg::DIM_W'(zpc_pkg::MAX_WIDTH) : width_r;
  assign eff_h = (height_r == '0) ? zpc_pkg::DIM_W'(1) :
                 (height_r > zpc_pkg::DIM_W'(zpc_pkg::MAX_HEIGHT)) ?
                 zpc_pkg::DIM_W'(zpc_pkg::MAX_HEIGHT) : height_r;

  // Front end: accept each transfer, mask out-of-frame pixels, tag borders.
  zpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .restart   (restart),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  zpc_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  // Back end: line store, window, multiply-accumulate, divide, clamp.
  zpc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .empty   (empty),
    .head    (head),
    .pop     (pop),
    .krow    (krow_r),
    .divisor (divisor_r),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

FILE: tb/conv_checker.sv
`timescale 1ns / 1ps
module conv_checker (
  input  logic clk,
  input  logic rst_n,
  zpc_cfg_if   cfg_ch,
  zpc_in_if    in_ch,
  zpc_out_if   out_ch,
  output int   fail_count,
  output int   pending
);

  localparam int HIST_DEPTH = 2 * zpc_pkg::MAX_WIDTH + 4;

  typedef struct packed {
    logic [zpc_pkg::PIX_W-1:0] pix;
    logic                      last;
  } conv_result_t;

  logic [zpc_pkg::DIM_W-1:0]         width_reg, height_reg;
  logic [zpc_pkg::KROW_W-1:0]        krow [zpc_pkg::KERNEL_SIZE];
  logic signed [zpc_pkg::DIVR_W-1:0] divisor_reg;
  logic [zpc_pkg::PIX_W-1:0]         history [HIST_DEPTH];
  int unsigned                       in_col, in_row, out_col, out_row;
  conv_result_t                      expected_q [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic int unsigned frame_w();
    if (width_reg == 0) return 1;
    if (width_reg > zpc_pkg::MAX_WIDTH) return zpc_pkg::MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned frame_h();
    if (height_reg == 0) return 1;
    if (height_reg > zpc_pkg::MAX_HEIGHT) return zpc_pkg::MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic void restart();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  // Store the sample, advance, and queue the pixel that this transfer completes.
  function automatic void convolve(logic mode, logic [zpc_pkg::PIX_W-1:0] pix);
    int unsigned w, h, k, pos;
    int sum, rr, cc, coef;
    logic [zpc_pkg::PIX_W-1:0] tap, sample;
    conv_result_t res;
    w = frame_w();
    h = frame_h();
    k = in_row * w + in_col;
    sample = (!mode && in_row < h) ? pix : '0;
    history[k % HIST_DEPTH] = sample;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (k < w + 1) return;
    pos = k - w - 1;
    sum = 0;
    for (int x = 0; x < zpc_pkg::KERNEL_SIZE; x++) begin
      for (int y = 0; y < zpc_pkg::KERNEL_SIZE; y++) begin
        rr = int'(out_row) + x - 1;
        cc = int'(out_col) + y - 1;
        tap = '0;
        if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w))
          tap = history[(rr * w + cc) % HIST_DEPTH];
        coef = $signed(krow[x][y*zpc_pkg::COEF_BITS +: zpc_pkg::COEF_BITS]);
        sum += coef * int'(tap);
      end
    end
    if (divisor_reg != 0) sum = sum / int'(divisor_reg);
    if (sum > 255) sum = 255;
    if (sum < 0) sum = 0;
    res.pix = sum[zpc_pkg::PIX_W-1:0];
    res.last = (pos + 1 >= w * h);
    expected_q.push_back(res);
    if (res.last) begin
      restart();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endfunction

  always @(posedge clk) begin
    conv_result_t want;
    if (!rst_n) begin
      width_reg = 640;
      height_reg = 480;
      krow[0] = '0;
      krow[1] = 24'd256;
      krow[2] = '0;
      divisor_reg = '0;
      expected_q.delete();
      restart();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          zpc_pkg::REG_WIDTH: begin
            width_reg = cfg_ch.data[zpc_pkg::DIM_W-1:0];
            restart();
          end
          zpc_pkg::REG_HEIGHT: begin
            height_reg = cfg_ch.data[zpc_pkg::DIM_W-1:0];
            restart();
          end
          zpc_pkg::REG_KTOP:    krow[0] = cfg_ch.data[zpc_pkg::KROW_W-1:0];
          zpc_pkg::REG_KMID:    krow[1] = cfg_ch.data[zpc_pkg::KROW_W-1:0];
          zpc_pkg::REG_KBOT:    krow[2] = cfg_ch.data[zpc_pkg::KROW_W-1:0];
          zpc_pkg::REG_DIVISOR: divisor_reg = cfg_ch.data[zpc_pkg::DIVR_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected output pix %0d last %0b", $time,
                   out_ch.pixel_out, out_ch.frame_last);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_ch.pixel_out !== want.pix || out_ch.frame_last !== want.last) begin
            $display("%0t: mismatch expected pix %0d last %0b, got pix %0d last %0b",
                     $time, want.pix, want.last, out_ch.pixel_out, out_ch.frame_last);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) convolve(in_ch.mode, in_ch.pixel);
    end
    pending = expected_q.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;
  localparam int SETTLE_CYCLES = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending;
  int   sent_count = 0;
  int   burst_left = 0;
  int   stall_style = 0;

  zpc_cfg_if cfg_ch ();
  zpc_in_if  in_ch ();
  zpc_out_if out_ch ();

  always #1 clk = ~clk;

  zero_padded_convolution_3x3 dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  conv_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ch     (cfg_ch),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver: switch stall style between stretches so long full-speed stretches
  // alternate with random and periodic back-pressure.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      stall_style = $urandom_range(2);
      for (int c = 0; c < 64; c++) begin
        @(negedge clk);
        case (stall_style)
          0: out_ch.ready = 1'b1;
          1: out_ch.ready = 1'($urandom_range(1));
          default: out_ch.ready = (c % 5) < 3;
        endcase
      end
    end
  end

  // Sender: hold valid across a burst, drop it for a random gap between bursts.
  task automatic send_item(input logic mode, input logic [zpc_pkg::PIX_W-1:0] pix);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_ch.valid = 1'b1;
    in_ch.mode = mode;
    in_ch.pixel = pix;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    burst_left--;
    sent_count++;
  endtask

  // Wait until every pending output has arrived and the back end is quiet.
  task automatic settle();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [zpc_pkg::IDX_W-1:0] idx,
                           input logic [zpc_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic configure(input int w, input int h,
                           input logic [zpc_pkg::KROW_W-1:0] k0,
                           input logic [zpc_pkg::KROW_W-1:0] k1,
                           input logic [zpc_pkg::KROW_W-1:0] k2,
                           input logic [zpc_pkg::DIVR_W-1:0] div);
    settle();
    write_reg(zpc_pkg::REG_WIDTH, zpc_pkg::CFG_DATA_W'(w));
    write_reg(zpc_pkg::REG_HEIGHT, zpc_pkg::CFG_DATA_W'(h));
    write_reg(zpc_pkg::REG_KTOP, k0);
    write_reg(zpc_pkg::REG_KMID, k1);
    write_reg(zpc_pkg::REG_KBOT, k2);
    write_reg(zpc_pkg::REG_DIVISOR, zpc_pkg::CFG_DATA_W'(div));
    // Unmapped indexes must be ignored.
    if ($urandom_range(4) == 0)
      write_reg($urandom_range(1) ? zpc_pkg::IDX_W'(6) : zpc_pkg::IDX_W'(7),
                zpc_pkg::CFG_DATA_W'($urandom));
  endtask

  // One frame plus its drain. flush_pct puts flush ticks inside the frame;
  // mixed_drain sends real pixels past the frame end, which must be ignored.
  task automatic run_frame(input int w, input int h, input int flush_pct,
                           input bit mixed_drain);
    for (int i = 0; i < w * h; i++)
      send_item($urandom_range(99) < flush_pct ? MODE_FLUSH : MODE_PIXEL,
                zpc_pkg::PIX_W'($urandom));
    for (int i = 0; i <= w; i++)
      send_item(mixed_drain && $urandom_range(1) ? MODE_PIXEL : MODE_FLUSH,
                zpc_pkg::PIX_W'($urandom));
  endtask

  function automatic logic [zpc_pkg::COEF_BITS-1:0] pick_coef();
    case ($urandom_range(7))
      0: return 8'h7f;
      1: return 8'h80;
      2: return 8'h00;
      3: return 8'h01;
      default: return zpc_pkg::COEF_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [zpc_pkg::KROW_W-1:0] pick_krow();
    return {pick_coef(), pick_coef(), pick_coef()};
  endfunction

  function automatic logic [zpc_pkg::DIVR_W-1:0] pick_divisor();
    case ($urandom_range(9))
      0, 1, 2: return '0;
      3: return 9'd1;
      4: return 9'h1ff;  // -1
      5: return 9'd255;
      6: return 9'h101;  // -255
      default: return zpc_pkg::DIVR_W'(int'($urandom_range(510)) - 255);
    endcase
  endfunction

  initial begin
    int w, h;
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.pixel = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed: box sum that saturates high, with extremes and an in-frame flush.
    configure(3, 3, 24'h010101, 24'h010101, 24'h010101, '0);
    send_item(MODE_PIXEL, 8'hff);
    send_item(MODE_PIXEL, 8'h00);
    send_item(MODE_PIXEL, 8'hff);
    send_item(MODE_FLUSH, 8'hff);
    send_item(MODE_PIXEL, 8'h80);
    send_item(MODE_PIXEL, 8'h7f);
    send_item(MODE_PIXEL, 8'h01);
    send_item(MODE_PIXEL, 8'hfe);
    send_item(MODE_PIXEL, 8'hff);
    for (int i = 0; i < 4; i++) send_item(i % 2 ? MODE_PIXEL : MODE_FLUSH, 8'hff);
    // Most negative kernel clamps low; negative divisor flips the sign back.
    configure(2, 2, 24'h808080, 24'h808080, 24'h808080, 9'h1ff);
    run_frame(2, 2, 0, 1);
    configure(2, 1, 24'h7f7f7f, 24'h7f7f7f, 24'h7f7f7f, 9'd255);
    run_frame(2, 1, 0, 0);

    // Size extreme: zero reads as one.
    configure(0, 0, pick_krow(), pick_krow(), pick_krow(), pick_divisor());
    run_frame(1, 1, 0, 1);

    // Random: mostly well-formed frames with random content, some noise.
    while (sent_count < 650) begin
      w = $urandom_range(3) == 0 ? $urandom_range(1, 3) : $urandom_range(1, 12);
      h = $urandom_range(1, 6);
      configure(w, h, pick_krow(), pick_krow(), pick_krow(), pick_divisor());
      if ($urandom_range(6) == 0) begin
        repeat ($urandom_range(1, 20))
          send_item(1'($urandom_range(1)), zpc_pkg::PIX_W'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) run_frame(w, h, $urandom_range(1) ? 0 : 15,
                                               $urandom_range(1));
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
